// ===== rtl/i2da_pkg.sv =====
package i2da_pkg;

    localparam int VALUE_W    = 64;
    localparam int NUM_DIGITS = 20;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int CNT_W      = $clog2(VALUE_W);
    localparam int LEFT_W     = $clog2(NUM_DIGITS + 1);
    localparam int CHAR_W     = 6;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

endpackage

// ===== rtl/i2da_bcd.sv =====
module i2da_bcd
    import i2da_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [VALUE_W-1:0] i_value,
    output logic               o_done,
    output logic [BCD_W-1:0]   o_bcd
);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [VALUE_W-1:0] r_bin;
    logic [BCD_W-1:0]   r_bcd;
    logic [BCD_W-1:0]   n_adj;

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (r_bcd[4*i +: 4] >= 4'd5) begin
                n_adj[4*i +: 4] = r_bcd[4*i +: 4] + 4'd3;
            end else begin
                n_adj[4*i +: 4] = r_bcd[4*i +: 4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(VALUE_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bin <= i_value;
            r_bcd <= '0;
        end else if (r_busy) begin
            r_bin <= {r_bin[VALUE_W-2:0], 1'b0};
            r_bcd <= {n_adj[BCD_W-2:0], r_bin[VALUE_W-1]};
        end
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;

endmodule

// ===== rtl/int64_to_decimal_ascii.sv =====
// Converts a 64-bit value to its decimal ASCII text.
// Input channel (s): tdata carries the value, tuser bit 0 selects signed
// two's complement reading. A word is taken only while the block is idle.
// Output channel (m): one character per word, most significant first; tlast
// marks the final character. A negative signed value is preceded by '-'.
// The binary-to-BCD unit shifts one input bit per cycle and hands the digits
// over with a registered done. Leading zeros are then dropped at one digit
// per cycle (up to 19 of them) and characters leave one per cycle while the
// receiver accepts them; the next word is accepted as soon as the last
// character sits in the output register.
// When the receiver stalls, the output register holds its character and the
// emitter waits; nothing is dropped. Synchronous reset returns the block to
// idle and clears the output valid; no clearing pass is needed.
module int64_to_decimal_ascii
    import i2da_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [VALUE_W-1:0] i_s_tdata,  // [63:0] value
    input  logic               i_s_tuser,  // [0] signed_mode
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [7:0]         o_m_tdata,  // [5:0] char_code, [7:6] zero
    output logic               o_m_tlast   // last_char
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_EMIT
    } t_state;

    t_state              r_state, n_state;
    logic                r_neg, n_neg;
    logic                r_started, n_started;
    logic [LEFT_W-1:0]   r_left, n_left;
    logic [BCD_W-1:0]    r_digits, n_digits;
    logic                r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]   r_out_char, n_out_char;
    logic                r_out_last, n_out_last;

    logic                s_accept;
    logic                s_neg;
    logic [VALUE_W-1:0]  s_mag;
    logic                s_slot;
    logic [3:0]          s_top;
    logic                bcd_done;
    logic [BCD_W-1:0]    bcd_value;

    assign o_s_tready = (r_state == S_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign s_neg      = i_s_tuser && i_s_tdata[VALUE_W-1];
    assign s_mag      = s_neg ? (~i_s_tdata + VALUE_W'(1)) : i_s_tdata;
    assign s_slot     = !r_out_valid || i_m_tready;
    assign s_top      = r_digits[BCD_W-1 -: 4];

    i2da_bcd u_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_accept),
        .i_value (s_mag),
        .o_done  (bcd_done),
        .o_bcd   (bcd_value)
    );

    always_comb begin
        n_state     = r_state;
        n_neg       = r_neg;
        n_started   = r_started;
        n_left      = r_left;
        n_digits    = r_digits;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_state = S_CONV;
                    n_neg   = s_neg;
                end
            end
            S_CONV: begin
                if (bcd_done) begin
                    n_digits  = bcd_value;
                    n_left    = LEFT_W'(NUM_DIGITS);
                    n_started = 1'b0;
                    n_state   = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_neg && !r_started && s_top == 4'd0 && r_left != LEFT_W'(1)) begin
                    // drop a leading zero
                    n_digits = {r_digits[BCD_W-5:0], 4'd0};
                    n_left   = r_left - LEFT_W'(1);
                end else if (s_slot) begin
                    n_out_valid = 1'b1;
                    if (r_neg) begin
                        n_out_char = CHAR_MINUS;
                        n_out_last = 1'b0;
                        n_neg      = 1'b0;
                    end else begin
                        n_out_char = CHAR_ZERO + {2'b00, s_top};
                        n_out_last = (r_left == LEFT_W'(1));
                        n_digits   = {r_digits[BCD_W-5:0], 4'd0};
                        n_left     = r_left - LEFT_W'(1);
                        n_started  = 1'b1;
                        if (r_left == LEFT_W'(1)) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_neg       <= 1'b0;
            r_started   <= 1'b0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_neg       <= n_neg;
            r_started   <= n_started;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
        r_digits   <= n_digits;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out_char};
    assign o_m_tlast  = r_out_last;

endmodule
